// File: sv/lsms_pkg.sv
// Shared types and constants of the LED and switch matrix scanner.
package lsms_pkg;

  localparam int LedRows    = 8;
  localparam int SwitchRows = 3;
  localparam int Columns    = 12;
  localparam int RowW       = 3;
  localparam int TickW      = 16;
  localparam int SwIdxW     = $clog2(SwitchRows);

  // Input commands.
  typedef enum logic [1:0] {
    CmdTick       = 2'd0,
    CmdLedWrite   = 2'd1,
    CmdSwitchRead = 2'd2,
    CmdNone       = 2'd3
  } cmd_e;

  // Scan phases; the spare code restarts the frame on the next tick.
  typedef enum logic [1:0] {
    PhLedOn  = 2'd0,
    PhLedGap = 2'd1,
    PhSwitch = 2'd2,
    PhSpare  = 2'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgRunEnable = 2'd0,
    CfgLedOn     = 2'd1,
    CfgLedGap    = 2'd2,
    CfgSettle    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             run_enable;
    logic [TickW-1:0] led_on_ticks;
    logic [TickW-1:0] led_gap_ticks;
    logic [TickW-1:0] switch_settle_ticks;
  } cfg_t;

  // Pin levels held during the current tick.
  typedef struct packed {
    logic [Columns-1:0] col_drive;
    logic               col_drive_enable;
    logic [LedRows-1:0] led_row_enable;
    logic [SwitchRows-1:0] switch_row_sink;
  } pins_t;

  // Events of one tick, reported by the scan controller.
  typedef struct packed {
    logic              sample;
    logic              frame_done;
    logic [SwIdxW-1:0] sw_row;
  } scan_evt_t;

endpackage

// File: sv/lsms_scan_ctrl.sv
// Scan sequencer: phase, row and tick counters, pin levels and sampling events.
module lsms_scan_ctrl
  import lsms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               tick_i,
  input  logic [Columns-1:0] led_row_bits_i,
  output logic [RowW-1:0]    row_o,
  output pins_t              pins_o,
  output scan_evt_t          evt_o
);

  phase_e           phase_q, phase_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic [TickW:0]   tick_inc;
  logic [TickW-1:0] on_lim;
  logic [TickW-1:0] settle_lim;
  logic             led_row_ok;
  logic             sw_row_ok;
  logic             last_led_row;
  logic             last_sw_row;

  assign tick_inc     = {1'b0, tick_q} + {{TickW{1'b0}}, 1'b1};
  assign on_lim       = (cfg_i.led_on_ticks == '0) ? TickW'(1) : cfg_i.led_on_ticks;
  assign settle_lim   = (cfg_i.switch_settle_ticks == '0) ? TickW'(1)
                                                          : cfg_i.switch_settle_ticks;
  assign led_row_ok   = ({1'b0, row_q} < (RowW + 1)'(LedRows));
  assign sw_row_ok    = ({1'b0, row_q} < (RowW + 1)'(SwitchRows));
  assign last_led_row = (row_q == RowW'(LedRows - 1));
  assign last_sw_row  = (row_q == RowW'(SwitchRows - 1));

  // Next state of the scan on a tick.
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    tick_d  = tick_q;
    if (tick_i) begin
      if (!cfg_i.run_enable) begin
        phase_d = PhLedOn;
        row_d   = '0;
        tick_d  = '0;
      end else begin
        case (phase_q)
          PhLedOn: begin
            if (!led_row_ok) begin
              phase_d = PhLedOn;
              row_d   = '0;
              tick_d  = '0;
            end else if (tick_inc >= {1'b0, on_lim}) begin
              tick_d = '0;
              if (cfg_i.led_gap_ticks != '0) begin
                phase_d = PhLedGap;
              end else if (last_led_row) begin
                row_d   = '0;
                phase_d = PhSwitch;
              end else begin
                row_d = row_q + RowW'(1);
              end
            end else begin
              tick_d = tick_inc[TickW-1:0];
            end
          end
          PhLedGap: begin
            if (!led_row_ok) begin
              phase_d = PhLedOn;
              row_d   = '0;
              tick_d  = '0;
            end else if (tick_inc >= {1'b0, cfg_i.led_gap_ticks}) begin
              tick_d = '0;
              if (last_led_row) begin
                row_d   = '0;
                phase_d = PhSwitch;
              end else begin
                row_d   = row_q + RowW'(1);
                phase_d = PhLedOn;
              end
            end else begin
              tick_d = tick_inc[TickW-1:0];
            end
          end
          PhSwitch: begin
            if (!sw_row_ok) begin
              phase_d = PhLedOn;
              row_d   = '0;
              tick_d  = '0;
            end else if (tick_inc >= {1'b0, settle_lim}) begin
              tick_d = '0;
              if (last_sw_row) begin
                row_d   = '0;
                phase_d = PhLedOn;
              end else begin
                row_d = row_q + RowW'(1);
              end
            end else begin
              tick_d = tick_inc[TickW-1:0];
            end
          end
          default: begin
            phase_d = PhLedOn;
            row_d   = '0;
            tick_d  = '0;
          end
        endcase
      end
    end
  end

  // Pin levels of the current state and the sampling events of a tick.
  always_comb begin
    pins_o        = '0;
    evt_o         = '0;
    evt_o.sw_row  = row_q[SwIdxW-1:0];
    if (cfg_i.run_enable) begin
      case (phase_q)
        PhLedOn, PhLedGap: begin
          if (led_row_ok) begin
            pins_o.col_drive        = ~led_row_bits_i;
            pins_o.col_drive_enable = 1'b1;
            if (phase_q == PhLedOn) begin
              pins_o.led_row_enable = LedRows'(1) << row_q;
            end
          end
        end
        PhSwitch: begin
          if (sw_row_ok) begin
            pins_o.switch_row_sink = SwitchRows'(1) << row_q;
            if (tick_i && (tick_inc >= {1'b0, settle_lim})) begin
              evt_o.sample     = 1'b1;
              evt_o.frame_done = last_sw_row;
            end
          end
        end
        default: begin
          pins_o = '0;
        end
      endcase
    end
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLedOn;
      row_q   <= '0;
      tick_q  <= '0;
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      tick_q  <= tick_d;
    end
  end

  assign row_o = row_q;

  // The end of a frame is always a switch sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.frame_done |-> evt_o.sample)
    else $error("frame end without a switch sample");

  // LED rows and switch rows are never active together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|pins_o.led_row_enable) && (|pins_o.switch_row_sink)))
    else $error("LED row and switch row active together");

  // At most one LED row is lit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pins_o.led_row_enable))
    else $error("more than one LED row lit");

  // A tick while scanning is off restarts the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && !cfg_i.run_enable) |=>
      (phase_q == PhLedOn && row_q == '0 && tick_q == '0))
    else $error("scan not restarted while disabled");

endmodule

// File: sv/led_and_switch_matrix_scanner.sv
// Top level of the LED and switch matrix scanner: stores, config and output register.
// The block takes one command transfer per clock and delivers its result from an
// output register; it sustains one item per clock as long as the result side takes
// each transfer. A tick command reports the pin levels held for
// that tick and then steps the frame (LED rows lit and blanked in turn, then switch
// rows sunk and sampled); LED writes and switch reads report the pins unchanged.
// The scan position, the 8 LED rows and the 3 switch rows live in flip-flops, so
// there is no clearing pass after reset. Configuration writes are taken at once.
module led_and_switch_matrix_scanner
  import lsms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd[1:0], row_index[4:2], led_bits[16:5], col_sense[28:17], zero[31:29]
  input  logic [31:0] s_axis_tdata,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: col_drive[11:0], col_drive_enable[12], led_row_enable[20:13],
  //        switch_row_sink[23:21], switch_bits[35:24], zero[39:36]
  output logic [39:0] m_axis_tdata,
  // tlast: frame_done
  output logic        m_axis_tlast
);

  cfg_t               cfg_q;
  logic [Columns-1:0] led_store_q [LedRows];
  logic [Columns-1:0] switch_store_q [SwitchRows];

  logic               out_valid_q;
  logic [35:0]        out_data_q;
  logic               out_last_q;

  cmd_e               in_cmd;
  logic [RowW-1:0]    in_row;
  logic [Columns-1:0] in_led_bits;
  logic [Columns-1:0] in_col_sense;
  logic               accept;
  logic               tick;
  logic [RowW-1:0]    scan_row;
  pins_t              pins;
  scan_evt_t          evt;
  logic [Columns-1:0] switch_bits;

  assign in_cmd       = cmd_e'(s_axis_tdata[1:0]);
  assign in_row       = s_axis_tdata[4:2];
  assign in_led_bits  = s_axis_tdata[16:5];
  assign in_col_sense = s_axis_tdata[28:17];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = accept && (in_cmd == CmdTick);

  lsms_scan_ctrl u_scan_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .tick_i         (tick),
    .led_row_bits_i (led_store_q[scan_row]),
    .row_o          (scan_row),
    .pins_o         (pins),
    .evt_o          (evt)
  );

  // Stored switch row for a read command, zero otherwise.
  always_comb begin
    switch_bits = '0;
    if ((in_cmd == CmdSwitchRead) && (in_row < RowW'(SwitchRows))) begin
      switch_bits = switch_store_q[in_row[SwIdxW-1:0]];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_enable          <= 1'b0;
      cfg_q.led_on_ticks        <= 16'd300;
      cfg_q.led_gap_ticks       <= 16'd10;
      cfg_q.switch_settle_ticks <= 16'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRunEnable: cfg_q.run_enable          <= cfg_data_i[0];
        CfgLedOn:     cfg_q.led_on_ticks        <= cfg_data_i;
        CfgLedGap:    cfg_q.led_gap_ticks       <= cfg_data_i;
        CfgSettle:    cfg_q.switch_settle_ticks <= cfg_data_i;
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // LED row store, written by LED write commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LedRows; i++) begin
        led_store_q[i] <= '0;
      end
    end else if (accept && (in_cmd == CmdLedWrite) &&
                 ({1'b0, in_row} < (RowW + 1)'(LedRows))) begin
      led_store_q[in_row] <= in_led_bits;
    end
  end

  // Switch row store, written on the last settle tick of each switch row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SwitchRows; i++) begin
        switch_store_q[i] <= '0;
      end
    end else if (evt.sample) begin
      switch_store_q[evt.sw_row] <= in_col_sense;
    end
  end

  // Output register; a new transfer is loaded whenever the old one is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {switch_bits, pins.switch_row_sink, pins.led_row_enable,
                     pins.col_drive_enable, pins.col_drive};
      out_last_q <= evt.frame_done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};
  assign m_axis_tlast  = out_last_q;

  // Released columns never carry a drive level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[12]) |-> (out_data_q[11:0] == '0))
    else $error("column levels set while columns are released");

endmodule
